/* hw/rtl/trimmed_mean_adc_filter_top_defines.svh */
// Assertion helpers used by the filter top level.
`ifndef TRIMMED_MEAN_ADC_FILTER_TOP_DEFINES_SVH
`define TRIMMED_MEAN_ADC_FILTER_TOP_DEFINES_SVH
`ifndef SYNTHESIS
// Property that must hold at every clock edge outside reset.
`define TMAF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);
// Condition that must never be true outside reset.
`define TMAF_NEVER(lbl, cond, msg) \
  `TMAF_ASSERT(lbl, !(cond), msg)
`else
`define TMAF_ASSERT(lbl, prop, msg)
`define TMAF_NEVER(lbl, cond, msg)
`endif
`endif

/* hw/rtl/tmaf_pkg.sv */
package tmaf_pkg;

  // Default configuration of the filter
  localparam int CHANNELS_DEF    = 9;
  localparam int SAMPLES_DEF     = 10;
  localparam int SAMPLE_BITS_DEF = 16;
  localparam int FRAC_BITS_DEF   = 4;

  // Values dropped at each end of the sorted batch
  localparam int TRIM = 3;

  // Field widths
  localparam int CH_W       = 4;
  localparam int IN_W       = 16;
  localparam int CLIP_W     = 16;
  localparam int LEVEL_W    = 20;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 20;

  localparam logic [CLIP_W-1:0]  CLIP_RESET = 16'd500;
  localparam logic [LEVEL_W-1:0] MIN_RESET  = 20'd16;
  localparam logic [LEVEL_W-1:0] LEVEL_MAX  = 20'hFFFFF;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_CLIP_LIMIT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_LEVEL  = 2'd1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_DRAIN,
    S_TRIM,
    S_DIV,
    S_FIN
  } state_e;

  // Controller to datapath
  typedef struct packed {
    logic store;      // write the incoming sample
    logic scan_init;  // latch batch channel, clear accumulators
    logic rd_en;      // read next stored sample of the batch
    logic trim;       // form trimmed sum and load divider
    logic div_step;   // multiply by the divisor reciprocal
    logic finish;     // clamp and present the result
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic in_range;
    logic batch_last;
    logic scan_last;
  } sts_t;

endpackage

/* hw/rtl/trimmed_mean_adc_filter_top.sv */
// Trimmed-mean ADC filter. A sample transfer happens on a clock edge with
// start_i high and busy_o low; samples on channels at or above CHANNELS are
// dropped. A sample that does not complete its channel's batch leaves busy_o
// low, so such samples can follow each other every cycle. The sample that
// completes a batch raises busy_o after its transfer while the batch is read
// back one entry per cycle over the single read port of the sample memory;
// a drain step then takes in the last value read, and the trim, divide and
// finish steps form the trimmed sum, divide it by a multiplication with the
// divisor's reciprocal and clamp the level.
// The result shows on out_channel_o and level_o
// for exactly one cycle with done_o high, in the first cycle with busy_o low;
// the receiver cannot stall it, so it must take the result in that cycle.
// Configuration writes are always accepted (cfg_ready_o is tied high) and must
// only be issued while busy_o is low and no result is pending.
`include "trimmed_mean_adc_filter_top_defines.svh"

module trimmed_mean_adc_filter_top #(
  parameter int CHANNELS    = tmaf_pkg::CHANNELS_DEF,
  parameter int SAMPLES     = tmaf_pkg::SAMPLES_DEF,
  parameter int SAMPLE_BITS = tmaf_pkg::SAMPLE_BITS_DEF,
  parameter int FRAC_BITS   = tmaf_pkg::FRAC_BITS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  output logic                            busy_o,
  input  logic [tmaf_pkg::CH_W-1:0]       channel_i,
  input  logic [tmaf_pkg::IN_W-1:0]       sample_i,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [tmaf_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [tmaf_pkg::CFG_DATA_W-1:0] cfg_data_i,
  output logic                            done_o,
  output logic [tmaf_pkg::CH_W-1:0]       out_channel_o,
  output logic [tmaf_pkg::LEVEL_W-1:0]    level_o
);
  import tmaf_pkg::*;

  cmd_t cmd;
  sts_t sts;

  assign cfg_ready_o = 1'b1;

  tmaf_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .sts_i   (sts),
    .cmd_o   (cmd),
    .busy_o  (busy_o)
  );

  tmaf_dp #(
    .CHANNELS    (CHANNELS),
    .SAMPLES     (SAMPLES),
    .SAMPLE_BITS (SAMPLE_BITS),
    .FRAC_BITS   (FRAC_BITS)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .channel_i     (channel_i),
    .sample_i      (sample_i[SAMPLE_BITS-1:0]),
    .cfg_we_i      (cfg_valid_i && cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .done_o        (done_o),
    .out_channel_o (out_channel_o),
    .level_o       (level_o)
  );

  // Result strobe lasts a single cycle
  `TMAF_ASSERT(a_done_single, done_o |=> !done_o, "result strobe held for more than one cycle")
  // A result follows the end of a busy period
  `TMAF_ASSERT(a_done_after_busy, done_o |-> $past(busy_o), "result without batch work")
  // Completing sample starts batch work
  `TMAF_ASSERT(a_last_goes_busy,
    (start_i && !busy_o && sts.in_range && sts.batch_last) |=> busy_o,
    "batch completion did not start processing")
  // No sample write while a batch is in progress
  `TMAF_NEVER(a_no_store_busy, busy_o && cmd.store, "sample stored while busy")

endmodule

/* hw/rtl/tmaf_ctrl.sv */
module tmaf_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  input  tmaf_pkg::sts_t sts_i,
  output tmaf_pkg::cmd_t cmd_o,
  output logic           busy_o
);
  import tmaf_pkg::*;

  state_e state_q, state_d;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (start_i && sts_i.in_range && sts_i.batch_last) begin
          state_d = S_SCAN;
        end
      end
      S_SCAN: begin
        if (sts_i.scan_last) begin
          state_d = S_DRAIN;
        end
      end
      S_DRAIN: state_d = S_TRIM;
      S_TRIM:  state_d = S_DIV;
      S_DIV:   state_d = S_FIN;
      S_FIN:   state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // Commands
  always_comb begin
    cmd_o  = '0;
    busy_o = 1'b1;
    unique case (state_q)
      S_IDLE: begin
        busy_o          = 1'b0;
        cmd_o.store     = start_i && sts_i.in_range;
        cmd_o.scan_init = start_i && sts_i.in_range && sts_i.batch_last;
      end
      S_SCAN:  cmd_o.rd_en    = 1'b1;
      S_DRAIN: ;
      S_TRIM:  cmd_o.trim     = 1'b1;
      S_DIV:   cmd_o.div_step = 1'b1;
      S_FIN:   cmd_o.finish   = 1'b1;
      default: ;
    endcase
  end

endmodule

/* hw/rtl/tmaf_dp.sv */
module tmaf_dp #(
  parameter int CHANNELS    = tmaf_pkg::CHANNELS_DEF,
  parameter int SAMPLES     = tmaf_pkg::SAMPLES_DEF,
  parameter int SAMPLE_BITS = tmaf_pkg::SAMPLE_BITS_DEF,
  parameter int FRAC_BITS   = tmaf_pkg::FRAC_BITS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  tmaf_pkg::cmd_t                 cmd_i,
  output tmaf_pkg::sts_t                 sts_o,
  input  logic [tmaf_pkg::CH_W-1:0]      channel_i,
  input  logic [SAMPLE_BITS-1:0]         sample_i,
  input  logic                           cfg_we_i,
  input  logic [tmaf_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [tmaf_pkg::CFG_DATA_W-1:0] cfg_data_i,
  output logic                           done_o,
  output logic [tmaf_pkg::CH_W-1:0]      out_channel_o,
  output logic [tmaf_pkg::LEVEL_W-1:0]   level_o
);
  import tmaf_pkg::*;

  localparam int DEPTH    = CHANNELS * SAMPLES;
  localparam int ADDR_W   = $clog2(DEPTH);
  localparam int CH_IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int IDX_W    = $clog2(SAMPLES);
  localparam int SUM_W    = SAMPLE_BITS + $clog2(SAMPLES);
  localparam int NUM_W    = SUM_W + FRAC_BITS;
  localparam int DIVISOR  = SAMPLES - 2 * TRIM;
  localparam int CMP_W    = (NUM_W > LEVEL_W) ? NUM_W : LEVEL_W;

  // Reciprocal of the divisor, rounded up; exact over every NUM_W-bit numerator
  localparam int DIV_L  = $clog2(DIVISOR);
  localparam int RCP_SH = NUM_W + DIV_L;
  localparam int RCP_W  = NUM_W + 1;
  localparam int PROD_W = NUM_W + RCP_W;
  localparam longint unsigned RCP =
    ((64'd1 << RCP_SH) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR);
  localparam logic [RCP_W-1:0] RCP_M = RCP_W'(RCP);

  // Configuration registers
  logic [CLIP_W-1:0]  clip_q;
  logic [LEVEL_W-1:0] min_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clip_q <= CLIP_RESET;
      min_q  <= MIN_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_CLIP_LIMIT: clip_q <= cfg_data_i[CLIP_W-1:0];
        CFG_MIN_LEVEL:  min_q  <= cfg_data_i[LEVEL_W-1:0];
        default: ;
      endcase
    end
  end

  // Per-channel fill counters
  logic [IDX_W-1:0]    fill_q [CHANNELS];
  logic [CH_IDX_W-1:0] ch_idx;
  logic [IDX_W-1:0]    fill_n;
  logic                batch_last;
  logic [ADDR_W-1:0]   ch_base;
  logic [ADDR_W-1:0]   wr_addr;

  assign ch_idx     = channel_i[CH_IDX_W-1:0];
  assign fill_n     = fill_q[ch_idx];
  assign batch_last = (fill_n == IDX_W'(SAMPLES - 1));
  assign ch_base    = ADDR_W'(ch_idx) * ADDR_W'(SAMPLES);
  assign wr_addr    = ch_base + ADDR_W'(fill_n);

  assign sts_o.in_range   = ({1'b0, channel_i} < (CH_W + 1)'(CHANNELS));
  assign sts_o.batch_last = batch_last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < CHANNELS; i++) begin
        fill_q[i] <= '0;
      end
    end else if (cmd_i.store) begin
      fill_q[ch_idx] <= batch_last ? '0 : fill_n + IDX_W'(1);
    end
  end

  // Sample memory
  logic [SAMPLE_BITS-1:0] mem_q [DEPTH];
  logic [SAMPLE_BITS-1:0] rd_data_q;
  logic [ADDR_W-1:0]      rd_addr;

  always_ff @(posedge clk_i) begin
    if (cmd_i.store) begin
      mem_q[wr_addr] <= sample_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_en) begin
      rd_data_q <= mem_q[rd_addr];
    end
  end

  // Batch scan control
  logic [CH_W-1:0]   bch_q;
  logic [ADDR_W-1:0] base_q;
  logic [IDX_W-1:0]  idx_q;
  logic              rd_vld_q;

  assign rd_addr         = base_q + ADDR_W'(idx_q);
  assign sts_o.scan_last = (idx_q == IDX_W'(SAMPLES - 1));

  always_ff @(posedge clk_i) begin
    if (cmd_i.scan_init) begin
      bch_q  <= channel_i;
      base_q <= ch_base;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      rd_vld_q <= cmd_i.rd_en;
      if (cmd_i.scan_init) begin
        idx_q <= '0;
      end else if (cmd_i.rd_en) begin
        idx_q <= idx_q + IDX_W'(1);
      end
    end
  end

  // Clip the value read back
  logic [SAMPLE_BITS-1:0] clip_v;

  assign clip_v = (CLIP_W'(rd_data_q) > clip_q) ? clip_q[SAMPLE_BITS-1:0] : rd_data_q;

  // Running total plus the TRIM lowest and TRIM highest values
  logic [SUM_W-1:0]       tot_q;
  logic [SAMPLE_BITS-1:0] lo_q [TRIM];
  logic [SAMPLE_BITS-1:0] hi_q [TRIM];
  logic [SAMPLE_BITS-1:0] lo_d [TRIM];
  logic [SAMPLE_BITS-1:0] hi_d [TRIM];

  // Insert into ascending low list and descending high list
  always_comb begin
    for (int k = 0; k < TRIM; k++) begin
      lo_d[k] = lo_q[k];
      hi_d[k] = hi_q[k];
      if (clip_v < lo_q[k]) begin
        lo_d[k] = (k > 0 && lo_q[(k > 0) ? k - 1 : 0] > clip_v) ?
                  lo_q[(k > 0) ? k - 1 : 0] : clip_v;
      end
      if (clip_v > hi_q[k]) begin
        hi_d[k] = (k > 0 && hi_q[(k > 0) ? k - 1 : 0] < clip_v) ?
                  hi_q[(k > 0) ? k - 1 : 0] : clip_v;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.scan_init) begin
      tot_q <= '0;
      for (int k = 0; k < TRIM; k++) begin
        lo_q[k] <= '1;
        hi_q[k] <= '0;
      end
    end else if (rd_vld_q) begin
      tot_q <= tot_q + SUM_W'(clip_v);
      for (int k = 0; k < TRIM; k++) begin
        lo_q[k] <= lo_d[k];
        hi_q[k] <= hi_d[k];
      end
    end
  end

  // Trimmed sum: drop both ends from the total
  logic [SUM_W-1:0] ends_sum;
  logic [SUM_W-1:0] trim_sum;

  always_comb begin
    ends_sum = '0;
    for (int k = 0; k < TRIM; k++) begin
      ends_sum = ends_sum + SUM_W'(lo_q[k]) + SUM_W'(hi_q[k]);
    end
  end

  assign trim_sum = tot_q - ends_sum;

  // Load the scaled sum, then divide it in one step by the reciprocal multiply
  logic [NUM_W-1:0]  quo_q;
  logic [PROD_W-1:0] prod;

  assign prod = PROD_W'(quo_q) * PROD_W'(RCP_M);

  always_ff @(posedge clk_i) begin
    if (cmd_i.trim) begin
      quo_q <= NUM_W'(trim_sum) << FRAC_BITS;
    end else if (cmd_i.div_step) begin
      quo_q <= NUM_W'(prod >> RCP_SH);
    end
  end

  // Floor at min_level, saturate to the level field
  logic [CMP_W-1:0]   floored;
  logic [LEVEL_W-1:0] level_d;

  assign floored = (CMP_W'(quo_q) < CMP_W'(min_q)) ? CMP_W'(min_q) : CMP_W'(quo_q);
  assign level_d = (floored > CMP_W'(LEVEL_MAX)) ? LEVEL_MAX : floored[LEVEL_W-1:0];

  // Result register, strobe lasts one cycle
  logic                done_q;
  logic [CH_W-1:0]     out_ch_q;
  logic [LEVEL_W-1:0]  level_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= cmd_i.finish;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      out_ch_q <= bch_q;
      level_q  <= level_d;
    end
  end

  assign done_o        = done_q;
  assign out_channel_o = out_ch_q;
  assign level_o       = level_q;

endmodule

/* tb/sv/testbench.sv */
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import tmaf_pkg::*;

  localparam int NCH  = CHANNELS_DEF;
  localparam int NSMP = SAMPLES_DEF;
  localparam int KEEP = NSMP - 2 * TRIM;
  // Busy time of a batch-completing sample: readback, trim, divide and clamp
  localparam int BUSY_CYCLES   = NSMP + 4;
  localparam int SETTLE_CYCLES = 4;
  localparam int TIME_LIMIT_NS = 5_000_000;

  // Register indexes with no register behind them
  localparam logic [CFG_IDX_W-1:0] CFG_RSVD_2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_RSVD_3 = 2'd3;

  typedef struct packed {
    logic [CH_W-1:0]    ch;
    logic [LEVEL_W-1:0] level;
  } level_rec_t;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  start_i;
  logic                  busy_o;
  logic [CH_W-1:0]       channel_i;
  logic [IN_W-1:0]       sample_i;
  logic                  cfg_valid_i;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;
  logic                  done_o;
  logic [CH_W-1:0]       out_channel_o;
  logic [LEVEL_W-1:0]    level_o;

  // Filter state as the testbench sees it
  logic [CLIP_W-1:0]  clip_limit_q = CLIP_RESET;
  logic [LEVEL_W-1:0] min_level_q  = MIN_RESET;
  logic [IN_W-1:0]    batch_mem [NCH][NSMP];
  int unsigned        fill_cnt  [NCH];
  level_rec_t         expected_levels [$];

  int errors;
  int samples_taken;
  int samples_dropped;
  int levels_checked;
  int reg_writes;
  int settings_run;

  trimmed_mean_adc_filter_top dut (.*);

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    #(TIME_LIMIT_NS);
    $display("Timeout at %0t with %0d levels outstanding", $time, expected_levels.size());
    $display("Mismatches found");
    $finish;
  end

  // Clip, sort, trim both ends, average, floor and saturate one channel's batch
  function automatic logic [LEVEL_W-1:0] trimmed_level(input int ch);
    logic [CLIP_W-1:0] vals [NSMP];
    logic [CLIP_W-1:0] v;
    longint unsigned   total;
    longint unsigned   mean;
    int                j;
    total = 0;
    for (int i = 0; i < NSMP; i++) begin
      vals[i] = (batch_mem[ch][i] > clip_limit_q) ? clip_limit_q : batch_mem[ch][i];
    end
    for (int i = 1; i < NSMP; i++) begin
      v = vals[i];
      j = i;
      while (j > 0 && vals[j-1] > v) begin
        vals[j] = vals[j-1];
        j--;
      end
      vals[j] = v;
    end
    for (int i = TRIM; i < NSMP - TRIM; i++) begin
      total += vals[i];
    end
    mean = (total << FRAC_BITS_DEF) / KEEP;
    if (mean < min_level_q) mean = min_level_q;
    if (mean > LEVEL_MAX) mean = LEVEL_MAX;
    return mean[LEVEL_W-1:0];
  endfunction

  // Check results, follow register writes and predict on each sample transfer
  always @(posedge clk_i) begin
    level_rec_t  want;
    level_rec_t  rec;
    int unsigned slot;
    if (rst_ni) begin
      if (done_o) begin
        if (expected_levels.size() == 0) begin
          errors++;
          $display("%0t: unexpected level, expected none, actual channel %0d level 0x%05h",
                   $time, out_channel_o, level_o);
        end else begin
          want = expected_levels.pop_front();
          levels_checked++;
          if (out_channel_o !== want.ch) begin
            errors++;
            $display("%0t: out_channel expected %0d actual %0d", $time, want.ch, out_channel_o);
          end
          if (level_o !== want.level) begin
            errors++;
            $display("%0t: level on channel %0d expected 0x%05h actual 0x%05h",
                     $time, want.ch, want.level, level_o);
          end
        end
      end
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          CFG_CLIP_LIMIT: clip_limit_q = cfg_data_i[CLIP_W-1:0];
          CFG_MIN_LEVEL:  min_level_q  = cfg_data_i[LEVEL_W-1:0];
          default: ;
        endcase
      end
      if (start_i && !busy_o) begin
        samples_taken++;
        if (channel_i < NCH) begin
          slot = fill_cnt[channel_i];
          batch_mem[channel_i][slot] = sample_i;
          slot++;
          if (slot == NSMP) begin
            fill_cnt[channel_i] = 0;
            rec.ch    = channel_i;
            rec.level = trimmed_level(channel_i);
            expected_levels.push_back(rec);
          end else begin
            fill_cnt[channel_i] = slot;
          end
        end else begin
          samples_dropped++;
        end
      end
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Spread samples over the full range, below the clip and around it
  function automatic logic [IN_W-1:0] pick_sample(input logic [CLIP_W-1:0] clip);
    int r;
    int v;
    r = $urandom_range(0, 99);
    if (r < 25) v = $urandom_range(0, 65535);
    else if (r < 45) v = $urandom_range(0, clip);
    else if (r < 60) begin
      v = int'(clip) + int'($urandom_range(0, 4)) - 2;
      if (v < 0) v = 0;
      if (v > 65535) v = 65535;
    end
    else if (r < 72) v = ($urandom_range(0, 1) != 0) ? 65535 : 0;
    else v = $urandom_range(0, 1023);
    return v[IN_W-1:0];
  endfunction

  // Hold one sample until its transfer, then idle for gap cycles
  task automatic send_sample(input logic [CH_W-1:0] ch, input logic [IN_W-1:0] smp,
                             input int gap);
    channel_i <= ch;
    sample_i  <= smp;
    start_i   <= 1'b1;
    do @(posedge clk_i); while (busy_o);
    if (gap > 0) begin
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Stop sending until every predicted level has come out
  task automatic wait_for_levels();
    start_i <= 1'b0;
    do @(posedge clk_i); while (expected_levels.size() != 0);
  endtask

  task automatic settle_for_config();
    wait_for_levels();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    cfg_valid_i <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
    reg_writes++;
  endtask

  task automatic apply_setting(input logic [CLIP_W-1:0] clip, input logic [LEVEL_W-1:0] floor_lvl);
    logic [CFG_DATA_W-CLIP_W-1:0] pad;
    pad = (CFG_DATA_W - CLIP_W)'($urandom_range(0, 2 ** (CFG_DATA_W - CLIP_W) - 1));
    settle_for_config();
    // upper data bits of a clip write are don't-care
    write_reg(CFG_CLIP_LIMIT, {pad, clip});
    write_reg(CFG_MIN_LEVEL, floor_lvl);
    settings_run++;
  endtask

  // Writes to unused indexes must leave both registers at reset;
  // the next batch runs with the reset values and shows it
  task automatic test_unused_index();
    write_reg(CFG_RSVD_2, '1);
    write_reg(CFG_RSVD_3, '0);
    write_reg(CFG_RSVD_2, '0);
    write_reg(CFG_RSVD_3, '1);
  endtask

  // One batch of corner samples on the top channel, with reset settings,
  // interleaved with samples on channels the filter lacks
  task automatic test_default_extremes();
    logic [IN_W-1:0] corner_vals [NSMP];
    corner_vals = '{16'h0000, 16'hFFFF, 16'd499, 16'd500, 16'd501,
                    16'h5555, 16'hAAAA, 16'd1, 16'h8000, 16'h7FFF};
    for (int i = 0; i < NSMP; i++) begin
      send_sample(CH_W'(NCH - 1), corner_vals[i], pick_gap());
      if (i == 2) send_sample(CH_W'(NCH), 16'hFFFF, 1);
      if (i == 6) send_sample({CH_W{1'b1}}, 16'hFFFF, 0);
    end
    wait_for_levels();
  endtask

  // Clipping must use the limit in force when the batch completes
  task automatic test_clip_change_mid_batch();
    for (int i = 0; i < NSMP; i++) begin
      if (i == NSMP / 2) begin
        settle_for_config();
        write_reg(CFG_CLIP_LIMIT, 20'hFFFFF);
      end
      send_sample('0, IN_W'($urandom_range(0, 2000)), pick_gap());
    end
    wait_for_levels();
  endtask

  // Random channels and samples under one register setting
  task automatic test_random_traffic(input logic [CLIP_W-1:0] clip,
                                     input logic [LEVEL_W-1:0] floor_lvl, input int count);
    int              burst_left;
    int              gap;
    logic [CH_W-1:0] ch;
    burst_left = 0;
    apply_setting(clip, floor_lvl);
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(0, 99) < 12) ch = CH_W'($urandom_range(NCH, 2 ** CH_W - 1));
      else ch = CH_W'($urandom_range(0, NCH - 1));
      if (burst_left > 0) begin
        gap = 0;
        burst_left--;
      end else begin
        gap = pick_gap();
        if ($urandom_range(0, 49) == 0) burst_left = $urandom_range(20, 40);
      end
      send_sample(ch, pick_sample(clip), gap);
      // now and then drain all outstanding levels before going on
      if ($urandom_range(0, 99) == 0) wait_for_levels();
    end
  endtask

  initial begin
    rst_ni      <= 1'b0;
    start_i     <= 1'b0;
    channel_i   <= '0;
    sample_i    <= '0;
    cfg_valid_i <= 1'b0;
    cfg_index_i <= CFG_CLIP_LIMIT;
    cfg_data_i  <= '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_unused_index();
    test_default_extremes();
    test_clip_change_mid_batch();
    test_random_traffic(CLIP_RESET, MIN_RESET, 170);
    test_random_traffic(16'hFFFF, 20'd0, 170);
    test_random_traffic(16'd0, 20'd0, 170);
    test_random_traffic(16'd0, 20'd1048560, 170);
    test_random_traffic(16'hFFFF, 20'hFFFFF, 170);
    test_random_traffic(CLIP_W'($urandom_range(0, 4095)), LEVEL_W'($urandom_range(0, 40000)), 170);
    test_random_traffic(CLIP_W'($urandom_range(0, 65535)), LEVEL_W'($urandom_range(0, 1048560)),
                        170);

    // let any stray result show up before judging
    wait_for_levels();
    repeat (BUSY_CYCLES + 8) @(posedge clk_i);
    if (expected_levels.size() != 0) begin
      errors++;
      $display("%0t: levels outstanding expected 0 actual %0d", $time, expected_levels.size());
    end

    $display("Sent %0d samples, %0d of them on channels the filter does not have",
             samples_taken, samples_dropped);
    $display("Checked %0d channel levels under %0d register settings (%0d register writes)",
             levels_checked, settings_run, reg_writes);
    if (errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
